[rtl/position_pid_clamped_integral_macros.svh]
// ----------------------------------------------------------------------------
// Position PID assertion macros
// Shorthand for the concurrent checks of the position PID block. Each macro
// samples on i_clk and is disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef POSITION_PID_CLAMPED_INTEGRAL_MACROS_SVH
`define POSITION_PID_CLAMPED_INTEGRAL_MACROS_SVH

// Same-cycle implication
`define PPCI_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("position_pid_clamped_integral: check failed");

// Next-cycle implication
`define PPCI_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("position_pid_clamped_integral: check failed");

`endif

[rtl/ppci_pkg.sv]
// ----------------------------------------------------------------------------
// Position PID package
// Widths, register indices, reset values and handshake structs shared by the
// position PID top level and its serial multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package ppci_pkg;

    // Gains are Q8.8, counts per turn is Q12.4 against Q8.8 turns
    localparam int GAIN_FRAC_BITS = 8;
    localparam int TGT_SHIFT      = 12;

    // Serial multiplier: signed multiplicand, signed multiplier digits
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 17;
    localparam int ACC_W   = 52;
    localparam int CNT_W   = 5;

    // Configuration register indices
    localparam int                CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] CFG_KP  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_KI  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_KD  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_CPT = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_LIM = 3'd4;

    localparam logic [15:0] CPT_RESET = 16'd17306;
    localparam logic [14:0] LIM_RESET = 15'd970;

    typedef struct packed {
        logic start;
        logic clear;
    } t_mul_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_stat;

endpackage

`default_nettype wire

[rtl/ppci_mul.sv]
// ----------------------------------------------------------------------------
// Serial multiply-accumulate
// Shift-and-add multiplier: one multiplier bit per cycle, the top bit
// weighted negative, products summed into a wide accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module ppci_mul import ppci_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_mul_req                  i_req,
    input  logic signed [MUL_A_W-1:0] i_a,
    input  logic signed [MUL_B_W-1:0] i_b,
    output t_mul_stat                 o_stat,
    output logic signed [ACC_W-1:0]   o_acc
);

    localparam logic [CNT_W-1:0] LAST = CNT_W'(MUL_B_W - 1);

    logic                    r_busy;
    logic                    r_done;
    logic [CNT_W-1:0]        r_cnt;
    logic signed [ACC_W-1:0] r_mcand;
    logic [MUL_B_W-1:0]      r_mplier;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] n_acc;

    // Sign bit of the multiplier carries negative weight
    always_comb begin
        if (r_mplier[0]) begin
            n_acc = (r_cnt == LAST) ? (r_acc - r_mcand) : (r_acc + r_mcand);
        end else begin
            n_acc = r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_mcand  <= ACC_W'(i_a);
            r_mplier <= i_b;
            if (i_req.clear) begin
                r_acc <= '0;
            end
        end else if (r_busy) begin
            r_acc    <= n_acc;
            r_mcand  <= r_mcand <<< 1;
            r_mplier <= r_mplier >> 1;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_acc       = r_acc;

endmodule

`default_nettype wire

[rtl/position_pid_clamped_integral.sv]
// ----------------------------------------------------------------------------
// Positional PID with clamped integral
// One request per control tick: scale the target in turns to encoder counts,
// form the saturated error, update the clamped integral and the derivative
// term, and return the saturated drive command.
// ----------------------------------------------------------------------------
// Each request runs through the single shared shift-and-add multiplier:
// four products (turns by counts per turn, then the three gain terms), each
// stepping through the 17 multiplier bits, one multiplier bit per cycle.
// The error and the integral clamp each have a state of their own. The input
// is taken again only once the block is back in idle, so the block takes no
// new request while one is still being worked; a finished drive sits in the
// output register, so a new request may be accepted while the last drive
// still waits to be taken, and the block holds its next drive until that one
// has gone. Configuration writes land at once and are to be issued only while
// no request is in flight.
`default_nettype none
`include "position_pid_clamped_integral_macros.svh"

module position_pid_clamped_integral import ppci_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Request stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [47:0]           i_s_axis_tdata,   // [15:0] target_turns, [47:16] measured_position
    // Drive stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [31:0]           o_m_axis_tdata,   // [31:0] drive
    // Configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [15:0]           i_cfg_wdata
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_TGT  = 8'b0000_0010,
        S_ERR  = 8'b0000_0100,
        S_INT  = 8'b0000_1000,
        S_MP   = 8'b0001_0000,
        S_MI   = 8'b0010_0000,
        S_MD   = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } t_state;

    localparam logic signed [32:0]      TGT_BIAS = 33'((64'(1) << TGT_SHIFT) - 1);
    localparam logic signed [ACC_W-1:0] SUM_BIAS = ACC_W'((64'(1) << GAIN_FRAC_BITS) - 1);

    // Configuration registers
    logic signed [15:0] r_kp;
    logic signed [15:0] r_ki;
    logic signed [15:0] r_kd;
    logic [15:0]        r_cpt;
    logic [14:0]        r_lim;

    // Control
    t_state   r_state;
    t_state   n_state;
    t_mul_req r_mul_req;
    t_mul_req n_mul_req;
    logic     r_ovalid;

    // Request payload and working values
    logic signed [15:0] r_turns;
    logic signed [31:0] r_pos;
    logic signed [31:0] r_err;
    logic signed [32:0] r_diff;
    logic [31:0]        r_drive;

    // Controller state kept between ticks
    logic signed [15:0] r_integ;
    logic signed [31:0] r_prev;

    // Multiplier
    t_mul_stat                 mul_stat;
    logic signed [ACC_W-1:0]   mul_acc;
    logic signed [MUL_A_W-1:0] w_mul_a;
    logic signed [MUL_B_W-1:0] w_mul_b;

    logic w_in_acc;
    logic w_out_load;

    // Error path
    logic signed [31:0] w_prod;
    logic signed [32:0] w_prod_bias;
    logic signed [32:0] w_target;
    logic signed [33:0] w_err_raw;
    logic signed [31:0] w_err;

    // Integral and derivative path
    logic signed [33:0] w_integ_raw;
    logic signed [33:0] w_lim;
    logic signed [33:0] w_nlim;
    logic signed [15:0] w_integ;
    logic signed [32:0] w_diff;

    // Drive path
    logic signed [ACC_W-1:0] w_sum_bias;
    logic signed [ACC_W-1:0] w_shift;
    logic [31:0]             w_drive;

    // Check helpers
    logic w_mul_step;
    logic w_integ_ok;

    assign w_in_acc   = i_s_axis_tvalid && (r_state == S_IDLE);
    assign w_out_load = (r_state == S_OUT) && (!r_ovalid || i_m_axis_tready);

    // Count target: truncate the Q.12 product toward zero, then saturate the error
    always_comb begin
        w_prod      = mul_acc[31:0];
        w_prod_bias = 33'(w_prod) + (w_prod[31] ? TGT_BIAS : 33'sd0);
        w_target    = w_prod_bias >>> TGT_SHIFT;
        w_err_raw   = 34'(w_target) - 34'(r_pos);
        if ((&w_err_raw[33:31]) || !(|w_err_raw[33:31])) begin
            w_err = w_err_raw[31:0];
        end else begin
            w_err = w_err_raw[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
    end

    // Integral: add, then clamp to the symmetric limit
    always_comb begin
        w_integ_raw = 34'(r_integ) + 34'(r_err);
        w_lim       = 34'($signed({1'b0, r_lim}));
        w_nlim      = -w_lim;
        priority if (w_integ_raw > w_lim) begin
            w_integ = w_lim[15:0];
        end else if (w_integ_raw < w_nlim) begin
            w_integ = w_nlim[15:0];
        end else begin
            w_integ = w_integ_raw[15:0];
        end
        w_diff = 33'(r_err) - 33'(r_prev);
    end

    // Drive: drop the gain fraction toward zero, then saturate
    always_comb begin
        w_sum_bias = mul_acc + (mul_acc[ACC_W-1] ? SUM_BIAS : '0);
        w_shift    = w_sum_bias >>> GAIN_FRAC_BITS;
        if ((&w_shift[ACC_W-1:31]) || !(|w_shift[ACC_W-1:31])) begin
            w_drive = w_shift[31:0];
        end else begin
            w_drive = w_shift[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
    end

    // Multiplier operands follow the step in progress
    always_comb begin
        unique case (r_state)
            S_TGT: begin
                w_mul_a = 34'(r_turns);
                w_mul_b = $signed({1'b0, r_cpt});
            end
            S_MP: begin
                w_mul_a = 34'(r_err);
                w_mul_b = 17'(r_kp);
            end
            S_MI: begin
                w_mul_a = 34'(r_integ);
                w_mul_b = 17'(r_ki);
            end
            S_MD: begin
                w_mul_a = 34'(r_diff);
                w_mul_b = 17'(r_kd);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // Sequencer: one multiply per step, the gain terms summed in place
    always_comb begin
        n_state   = r_state;
        n_mul_req = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state   = S_TGT;
                    n_mul_req = '{start: 1'b1, clear: 1'b1};
                end
            end
            S_TGT: begin
                if (mul_stat.done) begin
                    n_state = S_ERR;
                end
            end
            S_ERR: begin
                n_state = S_INT;
            end
            S_INT: begin
                n_state   = S_MP;
                n_mul_req = '{start: 1'b1, clear: 1'b1};
            end
            S_MP: begin
                if (mul_stat.done) begin
                    n_state   = S_MI;
                    n_mul_req = '{start: 1'b1, clear: 1'b0};
                end
            end
            S_MI: begin
                if (mul_stat.done) begin
                    n_state   = S_MD;
                    n_mul_req = '{start: 1'b1, clear: 1'b0};
                end
            end
            S_MD: begin
                if (mul_stat.done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control, configuration and kept state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_mul_req <= '0;
            r_ovalid  <= 1'b0;
            r_kp      <= '0;
            r_ki      <= '0;
            r_kd      <= '0;
            r_cpt     <= CPT_RESET;
            r_lim     <= LIM_RESET;
            r_integ   <= '0;
            r_prev    <= '0;
        end else begin
            r_state   <= n_state;
            r_mul_req <= n_mul_req;

            if (w_out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end

            // Drop writes to indices beyond the register list
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_KP:  r_kp  <= i_cfg_wdata;
                    CFG_KI:  r_ki  <= i_cfg_wdata;
                    CFG_KD:  r_kd  <= i_cfg_wdata;
                    CFG_CPT: r_cpt <= i_cfg_wdata;
                    CFG_LIM: r_lim <= i_cfg_wdata[14:0];
                    default: ;
                endcase
            end

            if (r_state == S_INT) begin
                r_integ <= w_integ;
                r_prev  <= r_err;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_turns <= i_s_axis_tdata[15:0];
            r_pos   <= i_s_axis_tdata[47:16];
        end
        if (r_state == S_ERR) begin
            r_err <= w_err;
        end
        if (r_state == S_INT) begin
            r_diff <= w_diff;
        end
        if (w_out_load) begin
            r_drive <= w_drive;
        end
    end

    ppci_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_mul_req),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_stat  (mul_stat),
        .o_acc   (mul_acc)
    );

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_drive;

    // Checks
    assign w_mul_step = (r_state == S_TGT) || (r_state == S_MP) ||
                        (r_state == S_MI) || (r_state == S_MD);
    assign w_integ_ok = (34'(r_integ) <= w_lim) && (34'(r_integ) >= w_nlim);

    `PPCI_ASSERT_NEXT(a_accept_starts, w_in_acc, r_state == S_TGT)
    `PPCI_ASSERT_IMPL(a_start_idle_mul, r_mul_req.start, !mul_stat.busy)
    `PPCI_ASSERT_IMPL(a_done_in_mul_step, mul_stat.done, w_mul_step)
    `PPCI_ASSERT_IMPL(a_integ_in_limit, r_state == S_OUT, w_integ_ok)

endmodule

`default_nettype wire
